[rtl/vrrq_pkg.sv]
//------------------------------------------------------------------------------
// vrrq_pkg: shared types and codes for the variable record ring queue.
// Holds the request and response payloads and the command and status codes.
//------------------------------------------------------------------------------
package vrrq_pkg;

   localparam logic [1:0] CMD_BEGIN_PUT = 2'd0;
   localparam logic [1:0] CMD_PUT_BYTE  = 2'd1;
   localparam logic [1:0] CMD_PEEK      = 2'd2;
   localparam logic [1:0] CMD_DELETE    = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_DENIED  = 2'd2;

   localparam logic [11:0] WRAP_LIMIT_RESET = 12'd4031;

   typedef struct packed {
      logic [1:0] command;
      logic [6:0] record_length;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic        last;
      logic [12:0] dropped_count;
   } rsp_type;

endpackage

[rtl/vrrq_ram.sv]
//------------------------------------------------------------------------------
// vrrq_ram: generic single-port RAM with registered read.
// One access per cycle to one address; a write also reads the old word there.
//------------------------------------------------------------------------------
module vrrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

[rtl/vrrq_front.sv]
//------------------------------------------------------------------------------
// vrrq_front: request intake.
// Holds accepted requests in a two-entry queue for the back end.
//------------------------------------------------------------------------------
module vrrq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vrrq_pkg::req_type req,
   output logic              q_valid,
   output vrrq_pkg::req_type q_req,
   input  logic              q_pop
);
   import vrrq_pkg::*;

   req_type    entry_ff [2];
   req_type    entry_in [2];
   logic [1:0] count_ff, count_in;
   logic       push;

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign q_req   = entry_ff[0];

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (q_pop && q_valid) begin
         entry_in[0] = entry_ff[1];
         count_in    = count_in - 2'd1;
      end
      if (push) begin
         entry_in[count_in[0]] = req;
         count_in              = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && q_pop) begin
         assert (q_valid) else $error("vrrq_front: pop from empty queue");
      end
   end
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("vrrq_front: queue count out of range");
endmodule

[rtl/vrrq_back.sv]
//------------------------------------------------------------------------------
// vrrq_back: command engine.
// Carries out one command at a time against the byte store and the pointers.
//------------------------------------------------------------------------------
module vrrq_back #(
   parameter int STORE_DEPTH = 4096,
   parameter int MAX_RECORD  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  vrrq_pkg::req_type q_req,
   output logic              q_pop,
   input  logic [11:0]       wrap_limit,
   output logic              idle,
   output logic              rsp_strobe,
   output vrrq_pkg::rsp_type rsp
);
   import vrrq_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);
   localparam int DW = $clog2(STORE_DEPTH + 1);
   localparam int CW = (AW > 12) ? AW + 1 : 13;

   typedef enum logic [2:0] {
      S_IDLE, S_DROP_RD, S_DROP_WAIT, S_DROP_EVAL, S_PEEK_HDR, S_PEEK_LEN, S_PEEK_BYTE,
      S_DEL_WAIT
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] head_ff, tail_ff, wptr_ff, start_ff, addr_ff;
   logic          open_ff;
   logic [6:0]    remain_ff, len_ff, cnt_ff;
   logic          wrap_ff;
   logic [DW-1:0] drops_ff;
   logic          strobe_ff;
   rsp_type       rsp_ff;
   logic          cmd_del_ff;

   logic          we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wdata, ram_rdata;

   vrrq_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(we), .addr(ram_addr), .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   // Combinational store access, driven from the current state and request.
   logic          hp_ge;
   logic [AW-1:0] start_c;
   logic          empty;
   logic [AW-1:0] raw_c;
   logic          need_drop;
   logic [AW+1:0] reach;

   assign hp_ge   = CW'(head_ff) >= CW'(wrap_limit);
   assign start_c = hp_ge ? '0 : head_ff;
   assign empty   = (head_ff == tail_ff);
   assign raw_c   = tail_ff + AW'(1) + AW'(ram_rdata);
   assign reach   = {2'b0, start_ff} + (AW+2)'(1) + (AW+2)'(len_ff);
   assign need_drop = (wrap_ff && tail_ff == '0) ||
                      (start_ff < tail_ff && reach >= {2'b0, tail_ff});

   always_comb begin
      we        = 1'b0;
      ram_addr  = addr_ff;
      ram_wdata = q_req.data_byte;
      q_pop     = 1'b0;
      if (state_ff == S_IDLE && q_valid && q_req.command == CMD_PUT_BYTE && open_ff) begin
         we       = 1'b1;
         ram_addr = wptr_ff;
      end else if (state_ff == S_DROP_EVAL && !(need_drop &&
                   drops_ff != DW'(STORE_DEPTH))) begin
         we        = 1'b1;
         ram_addr  = start_ff;
         ram_wdata = {1'b0, len_ff};
      end else if (state_ff == S_IDLE || state_ff == S_DROP_RD ||
                   state_ff == S_DROP_WAIT || state_ff == S_PEEK_HDR) begin
         ram_addr = tail_ff;
      end
      if (state_ff == S_IDLE && q_valid) begin
         q_pop = 1'b1;
      end
   end

   assign idle       = (state_ff == S_IDLE) && !q_valid && !strobe_ff;
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

   function automatic rsp_type mk(logic [1:0] st, logic [7:0] b, logic v, logic l,
                                  logic [12:0] d);
      rsp_type r;
      r.status = st; r.out_byte = b; r.byte_valid = v; r.last = l;
      r.dropped_count = d;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         wptr_ff   <= '0;
         open_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  case (q_req.command)
                     CMD_BEGIN_PUT: begin
                        if (open_ff || q_req.record_length > 7'(MAX_RECORD)) begin
                           strobe_ff <= 1'b1;
                           rsp_ff <= mk(STATUS_DENIED, 8'd0, 1'b0, 1'b1, 13'd0);
                        end else begin
                           start_ff <= start_c;
                           wrap_ff  <= hp_ge;
                           len_ff   <= q_req.record_length;
                           drops_ff <= '0;
                           if (empty) begin
                              tail_ff <= start_c;
                              addr_ff <= start_c;
                              state_ff <= S_DROP_EVAL;
                              // make need_drop false: tail equals start, no wrap
                              wrap_ff <= 1'b0;
                           end else begin
                              state_ff <= S_DROP_RD;
                           end
                        end
                     end
                     CMD_PUT_BYTE: begin
                        strobe_ff <= 1'b1;
                        if (!open_ff) begin
                           rsp_ff <= mk(STATUS_DENIED, 8'd0, 1'b0, 1'b1, 13'd0);
                        end else begin
                           rsp_ff <= mk(STATUS_OK, 8'd0, 1'b0, 1'b1, 13'd0);
                           wptr_ff <= wptr_ff + AW'(1);
                           remain_ff <= remain_ff - 7'd1;
                           if (remain_ff == 7'd1) begin
                              head_ff <= wptr_ff + AW'(1);
                              open_ff <= 1'b0;
                           end
                        end
                     end
                     default: begin
                        if (open_ff) begin
                           strobe_ff <= 1'b1;
                           rsp_ff <= mk(STATUS_DENIED, 8'd0, 1'b0, 1'b1, 13'd0);
                        end else if (empty) begin
                           strobe_ff <= 1'b1;
                           rsp_ff <= mk(STATUS_EMPTY, 8'd0, 1'b0, 1'b1, 13'd0);
                        end else begin
                           cmd_del_ff <= (q_req.command == CMD_DELETE);
                           state_ff   <= S_PEEK_HDR;
                        end
                     end
                  endcase
               end
            end
            S_DROP_RD:   state_ff <= S_DROP_WAIT;
            S_DROP_WAIT: state_ff <= S_DROP_EVAL;
            S_DROP_EVAL: begin
               // ram_rdata holds the header at tail (valid from a prior read).
               if (need_drop && drops_ff != DW'(STORE_DEPTH)) begin
                  drops_ff <= drops_ff + DW'(1);
                  if (raw_c == head_ff) begin
                     tail_ff <= start_ff;
                     wrap_ff <= 1'b0;
                     addr_ff <= start_ff;
                     state_ff <= S_DROP_EVAL;
                     // queue now empty: tail==start so need_drop is false next
                  end else begin
                     tail_ff  <= (CW'(raw_c) >= CW'(wrap_limit)) ? '0 : raw_c;
                     state_ff <= S_DROP_RD;
                  end
               end else begin
                  wptr_ff <= start_ff + AW'(1);
                  if (len_ff == 7'd0) begin
                     head_ff <= start_ff + AW'(1);
                  end else begin
                     open_ff   <= 1'b1;
                     remain_ff <= len_ff;
                  end
                  strobe_ff <= 1'b1;
                  rsp_ff <= mk(STATUS_OK, 8'd0, 1'b0, 1'b1, 13'(drops_ff));
                  state_ff <= S_IDLE;
               end
            end
            S_PEEK_HDR: begin
               // The tail header is read again here so that it arrives next cycle.
               state_ff <= cmd_del_ff ? S_DEL_WAIT : S_PEEK_LEN;
               addr_ff  <= tail_ff + AW'(1);
            end
            S_DEL_WAIT: begin
               tail_ff <= (raw_c == head_ff) ? head_ff :
                          ((CW'(raw_c) >= CW'(wrap_limit)) ? '0 : raw_c);
               strobe_ff <= 1'b1;
               rsp_ff <= mk(STATUS_OK, 8'd0, 1'b0, 1'b1, 13'd0);
               state_ff <= S_IDLE;
            end
            S_PEEK_LEN: begin
               len_ff <= (ram_rdata > 8'(MAX_RECORD)) ? 7'(MAX_RECORD) : ram_rdata[6:0];
               cnt_ff <= 7'd0;
               if (ram_rdata == 8'd0) begin
                  strobe_ff <= 1'b1;
                  rsp_ff <= mk(STATUS_OK, 8'd0, 1'b0, 1'b1, 13'd0);
                  state_ff <= S_IDLE;
               end else begin
                  addr_ff  <= addr_ff + AW'(1);
                  state_ff <= S_PEEK_BYTE;
               end
            end
            S_PEEK_BYTE: begin
               strobe_ff <= 1'b1;
               rsp_ff <= mk(STATUS_OK, ram_rdata, 1'b1, cnt_ff + 7'd1 == len_ff, 13'd0);
               cnt_ff  <= cnt_ff + 7'd1;
               addr_ff <= addr_ff + AW'(1);
               if (cnt_ff + 7'd1 == len_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_open_no_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DROP_RD) |-> !open_ff) else $error("vrrq_back: drop while open");
   a_one_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> state_ff != S_IDLE || strobe_ff) else $error("vrrq_back: pop lost");
   a_remain: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> remain_ff != 7'd0) else $error("vrrq_back: open with no bytes left");
endmodule

[rtl/variable_record_ring_queue.sv]
//------------------------------------------------------------------------------
// variable_record_ring_queue: byte ring of variable-length records.
// put_byte and refused or empty requests answer straight from the idle state;
// begin_put writes its header at once into an empty queue, else first drops
// tail records until the new record fits; peek reads the length, then gives
// one byte per cycle (none if zero-length); delete advances past the record.
// Throughput is set by the single-port byte store: one request at a time.
// Synchronous reset empties the queue and restores wrap_limit to 4031;
// the byte store keeps its contents. The receiver cannot stall responses.
//------------------------------------------------------------------------------
module variable_record_ring_queue #(
   parameter int STORE_DEPTH = 4096,
   parameter int MAX_RECORD  = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vrrq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output vrrq_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [11:0]       csr_wrap_limit
);
   import vrrq_pkg::*;

   // Wrap limit; the user writes it only while the queue is idle (not enforced).
   logic [11:0] wrap_limit_ff;
   logic        q_valid, q_pop, idle;
   req_type     q_req;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_limit_ff <= WRAP_LIMIT_RESET;
      end else if (csr_valid) begin
         wrap_limit_ff <= csr_wrap_limit;
      end
   end

   // Front end: queue of accepted requests.
   vrrq_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req(req_payload), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
   );

   // Back end: executes each request against the store.
   vrrq_back #(.STORE_DEPTH(STORE_DEPTH), .MAX_RECORD(MAX_RECORD)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_req(q_req),
      .q_pop(q_pop), .wrap_limit(wrap_limit_ff), .idle(idle),
      .rsp_strobe(rsp_strobe), .rsp(rsp_payload)
   );

   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> idle) else $error("csr write");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      idle |-> !rsp_strobe) else $error("response while idle");
   a_busy_queue: assert property (@(posedge clock) disable iff (reset)
      busy |-> q_valid) else $error("busy with empty queue");
endmodule
